/* hdl/fmrt_pkg.sv */
// Package for the first-match route table: table size, opcodes, entry layout,
// controller states and the command/status structs between control and datapath.
// No dependencies.
package fmrt_pkg;

  localparam int ROUTE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(ROUTE_ENTRIES);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    OP_LOOKUP    = 3'd0,
    OP_ADD       = 3'd1,
    OP_DEL_INDEX = 3'd2,
    OP_DEL_IFACE = 3'd3,
    OP_CLEAR     = 3'd4
  } op_e;

  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [31:0] next_hop;
    logic [7:0]  iface;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] dest_addr;
    logic [31:0] net_addr;
    logic [31:0] net_mask;
    logic [31:0] gateway;
    logic [7:0]  iface_id;
    logic [4:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] route_next_hop;
    logic [7:0]  route_iface;
    logic [4:0]  slot_used;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_WRITE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;    // take the request beat
    logic scan;    // read entry at scan counter, advance counter
    logic write;   // commit the add to its chosen slot
    logic finish;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    op_e  req_op;  // op of the beat on the request channel
    op_e  op;      // op of the beat being worked on
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

/* hdl/fmrt_if.sv */
// Request and response channel interfaces of the route table.
// Depends on fmrt_pkg for nothing but kept after it in compile order.
interface fmrt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] dest_addr;
  logic [31:0] net_addr;
  logic [31:0] net_mask;
  logic [31:0] gateway;
  logic [7:0]  iface_id;
  logic [4:0]  entry_index;

  modport source (output valid, op, dest_addr, net_addr, net_mask, gateway, iface_id,
                  entry_index, input ready);
  modport sink (input valid, op, dest_addr, net_addr, net_mask, gateway, iface_id,
                entry_index, output ready);
endinterface

interface fmrt_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] route_next_hop;
  logic [7:0]  route_iface;
  logic [4:0]  slot_used;

  modport source (output valid, hit, route_next_hop, route_iface, slot_used, input ready);
  modport sink (input valid, hit, route_next_hop, route_iface, slot_used, output ready);
endinterface

/* hdl/fmrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fmrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/fmrt_ctrl.sv */
// Controller FSM of the route table: sequences accept, scan, evaluate,
// write-back and result hand-off. Depends on fmrt_pkg.
module fmrt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  fmrt_pkg::sts_t sts_i,
  output fmrt_pkg::cmd_t cmd_o
);
  import fmrt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          // the op field is decoded in the datapath the same cycle
          if (sts_i.req_op == OP_LOOKUP || sts_i.req_op == OP_ADD ||
              sts_i.req_op == OP_DEL_IFACE) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // last entry read lands this cycle
        state_d = (sts_i.op == OP_ADD) ? ST_WRITE : ST_FINISH;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_SCAN || state_q == ST_FINISH))
    else $error("accepted beat did not start work");
  a_write_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write |-> $past(state_q) == ST_EVAL)
    else $error("write-back without a finished scan");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.scan, cmd_o.write, cmd_o.finish}))
    else $error("overlapping datapath commands");
`endif

endmodule

/* hdl/fmrt_dpath.sv */
// Datapath of the route table: request registers, valid bits, entry RAM,
// scan counter, match/free-slot tracking, replace pointer and output register.
// Depends on fmrt_pkg and fmrt_ram.
module fmrt_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fmrt_pkg::cmd_t cmd_i,
  output fmrt_pkg::sts_t sts_o,
  input  fmrt_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output fmrt_pkg::rsp_t rsp_o
);
  import fmrt_pkg::*;

  op_e         op_q;
  logic [31:0] dest_q, net_q, mask_q, gw_q;
  logic [7:0]  ifc_q;

  logic [ROUTE_ENTRIES-1:0] vld_q;
  idx_t ptr_q;
  idx_t cnt_q;
  logic scan_last;

  logic   eval_q;
  idx_t   eidx_q;
  logic   evld_q;
  entry_t rd_entry;

  logic        hit_q;
  logic [31:0] hop_q;
  logic [7:0]  rif_q;
  logic        match_q, free_q;
  idx_t        match_idx_q, free_idx_q;
  logic [4:0]  slot_q;

  logic        rsp_valid_q;
  rsp_t        rsp_q;

  logic        lookup_hit, add_match, add_free, iface_del;
  logic        del_idx_ok;
  idx_t        wr_slot;
  entry_t      wr_entry;

  assign scan_last = (cnt_q == IDX_W'(ROUTE_ENTRIES - 1));
  assign del_idx_ok = (32'(req_i.entry_index) < 32'(ROUTE_ENTRIES));

  assign wr_entry = '{network: net_q, mask: mask_q, next_hop: gw_q, iface: ifc_q};
  assign wr_slot  = match_q ? match_idx_q : (free_q ? free_idx_q : ptr_q);

  fmrt_ram #(
    .Width (ENTRY_W),
    .Depth (ROUTE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (wr_slot),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.scan),
    .raddr_i (cnt_q),
    .rdata_o (rd_entry)
  );

  // per-entry checks on the beat returned by the RAM
  assign lookup_hit = eval_q && evld_q && (op_q == OP_LOOKUP) && !hit_q &&
                      ((dest_q & rd_entry.mask) == (rd_entry.network & rd_entry.mask));
  assign add_match  = eval_q && evld_q && (op_q == OP_ADD) && !match_q &&
                      (rd_entry.network == net_q) && (rd_entry.mask == mask_q);
  assign add_free   = eval_q && !evld_q && (op_q == OP_ADD) && !free_q;
  assign iface_del  = eval_q && evld_q && (op_q == OP_DEL_IFACE) && (rd_entry.iface == ifc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(req_i.op);
      dest_q <= req_i.dest_addr;
      net_q  <= req_i.net_addr;
      mask_q <= req_i.net_mask;
      gw_q   <= req_i.gateway;
      ifc_q  <= req_i.iface_id;
    end
    if (cmd_i.scan) begin
      eidx_q <= cnt_q;
      evld_q <= vld_q[cnt_q];
    end
    if (lookup_hit) begin
      hop_q <= (rd_entry.next_hop == 32'd0) ? dest_q : rd_entry.next_hop;
      rif_q <= rd_entry.iface;
    end
    if (add_match) begin
      match_idx_q <= eidx_q;
    end
    if (add_free) begin
      free_idx_q <= eidx_q;
    end
    if (cmd_i.finish) begin
      rsp_q.hit            <= hit_q;
      rsp_q.route_next_hop <= hit_q ? hop_q : 32'd0;
      rsp_q.route_iface    <= hit_q ? rif_q : 8'd0;
      rsp_q.slot_used      <= slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      eval_q      <= 1'b0;
      hit_q       <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      slot_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      eval_q <= cmd_i.scan;
      if (cmd_i.load) begin
        cnt_q   <= '0;
        hit_q   <= 1'b0;
        match_q <= 1'b0;
        free_q  <= 1'b0;
        slot_q  <= '0;
        if (op_e'(req_i.op) == OP_CLEAR) begin
          vld_q <= '0;
          ptr_q <= '0;
        end else if (op_e'(req_i.op) == OP_DEL_INDEX && del_idx_ok) begin
          vld_q[IDX_W'(req_i.entry_index)] <= 1'b0;
        end
      end
      if (cmd_i.scan && !scan_last) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (lookup_hit) begin
        hit_q <= 1'b1;
      end
      if (add_match) begin
        match_q <= 1'b1;
      end
      if (add_free) begin
        free_q <= 1'b1;
      end
      if (iface_del) begin
        vld_q[eidx_q] <= 1'b0;
      end
      if (cmd_i.write) begin
        vld_q[wr_slot] <= 1'b1;
        slot_q         <= 5'(wr_slot);
        // table full: round-robin victim, pointer moves on
        if (!match_q && !free_q) begin
          ptr_q <= (ptr_q == IDX_W'(ROUTE_ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.req_op    = op_e'(req_i.op);
  assign sts_o.op        = op_q;
  assign sts_o.scan_last = scan_last;
  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < 32'(ROUTE_ENTRIES))
    else $error("replace pointer out of range");
  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |=> vld_q[$past(wr_slot)])
    else $error("written slot not marked valid");
  a_hit_only_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> op_q == OP_LOOKUP)
    else $error("hit flagged on a non-lookup op");
`endif

endmodule

/* hdl/first_match_route_table.sv */
// Top level of the first-match route table: wires the request/response
// channels to the controller and datapath. Depends on fmrt_pkg, fmrt_if,
// fmrt_ctrl, fmrt_dpath.
//
//   channel  dir  fields
//   req_i    in   op, dest_addr, net_addr, net_mask, gateway, iface_id, entry_index
//   rsp_o    out  hit, route_next_hop, route_iface, slot_used
//
// Lookup and delete-by-interface: after accept, one RAM read per entry, one state for
// the last read to land, then hand-off into the output register. Add has a write-back
// before hand-off. Other ops go from accept straight to hand-off. The next beat can be
// taken in the cycle after hand-off.
// Reset clears all valid bits and the replace pointer at once; no clearing pass.
// A stalled response holds its result and blocks hand-off, not the next accept.
module first_match_route_table (
  input logic     clk_i,
  input logic     rst_ni,
  fmrt_req_if.sink   req_i,
  fmrt_rsp_if.source rsp_o
);
  import fmrt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  req_t req;
  rsp_t rsp;

  assign req = '{op: req_i.op, dest_addr: req_i.dest_addr, net_addr: req_i.net_addr,
                 net_mask: req_i.net_mask, gateway: req_i.gateway,
                 iface_id: req_i.iface_id, entry_index: req_i.entry_index};

  fmrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fmrt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp)
  );

  assign rsp_o.hit            = rsp.hit;
  assign rsp_o.route_next_hop = rsp.route_next_hop;
  assign rsp_o.route_iface    = rsp.route_iface;
  assign rsp_o.slot_used      = rsp.slot_used;

endmodule

/* sim/first_match_route_table_test.sv */
// Self-checking testbench for first_match_route_table: drives request beats,
// predicts every response from its own model of the table and checks them in order.
// Depends on fmrt_pkg, fmrt_if and the RTL under hdl/.
module first_match_route_table_test;
  import fmrt_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int WATCHDOG_CYCLES = 600000;
  localparam int POOL_SIZE       = 48;
  localparam int MAX_REPORTS     = 10;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  logic clk_i;
  logic rst_ni;

  fmrt_req_if req_if ();
  fmrt_rsp_if rsp_if ();

  first_match_route_table u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // model of the table
  logic        tbl_valid [ROUTE_ENTRIES];
  logic [31:0] tbl_net   [ROUTE_ENTRIES];
  logic [31:0] tbl_mask  [ROUTE_ENTRIES];
  logic [31:0] tbl_hop   [ROUTE_ENTRIES];
  logic [7:0]  tbl_ifc   [ROUTE_ENTRIES];
  idx_t        repl_ptr;

  rsp_t route_answers_q [$];
  int   error_count;
  int   mismatch_count;
  int   send_idle_pct;
  int   recv_idle_pct;

  logic [31:0] pool_net  [POOL_SIZE];
  logic [31:0] pool_mask [POOL_SIZE];
  logic [7:0]  iface_pool [6] = '{8'd0, 8'd1, 8'd2, 8'd7, 8'd128, 8'd255};

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * WATCHDOG_CYCLES);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic rsp_t predict_route(req_t r);
    rsp_t res;
    logic found;
    logic have_free;
    idx_t slot;
    res = '0;
    found = 1'b0;
    have_free = 1'b0;
    slot = '0;
    case (r.op)
      OP_LOOKUP: begin
        for (int k = 0; k < ROUTE_ENTRIES; k++) begin
          if (tbl_valid[k] && ((r.dest_addr & tbl_mask[k]) == (tbl_net[k] & tbl_mask[k]))) begin
            res.hit = 1'b1;
            res.route_next_hop = (tbl_hop[k] == '0) ? r.dest_addr : tbl_hop[k];
            res.route_iface = tbl_ifc[k];
            break;
          end
        end
      end
      OP_ADD: begin
        for (int k = 0; k < ROUTE_ENTRIES; k++) begin
          if (!tbl_valid[k]) begin
            if (!have_free) begin
              have_free = 1'b1;
              slot = idx_t'(k);
            end
          end else if (tbl_net[k] == r.net_addr && tbl_mask[k] == r.net_mask) begin
            // update in place: network, mask, valid and pointer untouched
            tbl_hop[k] = r.gateway;
            tbl_ifc[k] = r.iface_id;
            slot = idx_t'(k);
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          if (!have_free) begin
            slot = repl_ptr;
            repl_ptr = (int'(slot) == ROUTE_ENTRIES - 1) ? '0 : slot + 1'b1;
          end
          tbl_net[slot]   = r.net_addr;
          tbl_mask[slot]  = r.net_mask;
          tbl_hop[slot]   = r.gateway;
          tbl_ifc[slot]   = r.iface_id;
          tbl_valid[slot] = 1'b1;
        end
        res.slot_used = 5'(slot);
      end
      OP_DEL_INDEX: begin
        if (int'(r.entry_index) < ROUTE_ENTRIES) tbl_valid[r.entry_index] = 1'b0;
      end
      OP_DEL_IFACE: begin
        for (int k = 0; k < ROUTE_ENTRIES; k++)
          if (tbl_valid[k] && tbl_ifc[k] == r.iface_id) tbl_valid[k] = 1'b0;
      end
      OP_CLEAR: begin
        for (int k = 0; k < ROUTE_ENTRIES; k++) tbl_valid[k] = 1'b0;
        repl_ptr = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t mk_req(logic [2:0] op, logic [31:0] dest, logic [31:0] net,
                                  logic [31:0] mask, logic [31:0] gw, logic [7:0] ifc,
                                  logic [4:0] idx);
    req_t r;
    r.op          = op;
    r.dest_addr   = dest;
    r.net_addr    = net;
    r.net_mask    = mask;
    r.gateway     = gw;
    r.iface_id    = ifc;
    r.entry_index = idx;
    return r;
  endfunction

  function automatic logic [31:0] prefix_mask(int len);
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  function automatic logic [31:0] random_mask();
    // mostly contiguous prefixes, now and then an arbitrary bit pattern
    if ($urandom_range(9) == 0) return $urandom;
    return prefix_mask($urandom_range(32));
  endfunction

  function automatic req_t random_background();
    return mk_req(3'($urandom), $urandom, $urandom, $urandom, $urandom, 8'($urandom),
                  5'($urandom));
  endfunction

  task automatic issue_request(input req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= r.op;
    req_if.dest_addr   <= r.dest_addr;
    req_if.net_addr    <= r.net_addr;
    req_if.net_mask    <= r.net_mask;
    req_if.gateway     <= r.gateway;
    req_if.iface_id    <= r.iface_id;
    req_if.entry_index <= r.entry_index;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    route_answers_q.push_back(predict_route(r));
  endtask

  task automatic quiet_request();
    req_if.valid <= 1'b0;
  endtask

  task automatic report_mismatch(string what, rsp_t want, rsp_t got);
    error_count++;
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: exp hit=%0b hop=%h if=%0d slot=%0d, got hit=%0b hop=%h if=%0d slot=%0d",
               $realtime, what, want.hit, want.route_next_hop, want.route_iface,
               want.slot_used, got.hit, got.route_next_hop, got.route_iface, got.slot_used);
  endtask

  // response side: random back-pressure and in-order compare
  initial begin : rsp_monitor
    rsp_t got;
    rsp_t want;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.hit            = rsp_if.hit;
        got.route_next_hop = rsp_if.route_next_hop;
        got.route_iface    = rsp_if.route_iface;
        got.slot_used      = rsp_if.slot_used;
        if (route_answers_q.size() == 0) begin
          report_mismatch("unexpected beat", '0, got);
        end else begin
          want = route_answers_q.pop_front();
          if (got.hit !== want.hit || got.route_next_hop !== want.route_next_hop ||
              got.route_iface !== want.route_iface || got.slot_used !== want.slot_used)
            report_mismatch("mismatch", want, got);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed();
    issue_request(mk_req(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0, '0));   // empty table
    issue_request(mk_req(OP_ADD, '0, 32'h0, 32'h0, 32'h0, 8'd0, '0));      // default route
    issue_request(mk_req(OP_ADD, '0, 32'h0A00_0000, 32'hFF00_0000, 32'hFFFF_FFFF, 8'd255,
                         '0));
    issue_request(mk_req(OP_LOOKUP, 32'h0A01_0203, '0, '0, '0, '0, '0));   // first match wins
    issue_request(mk_req(OP_ADD, '0, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 8'd7,
                         '0));                                              // update
    issue_request(mk_req(OP_DEL_INDEX, '0, '0, '0, '0, '0, 5'd0));
    issue_request(mk_req(OP_LOOKUP, 32'h0A01_0203, '0, '0, '0, '0, '0));
    issue_request(mk_req(OP_LOOKUP, 32'h0B00_0000, '0, '0, '0, '0, '0));   // miss
    issue_request(mk_req(OP_DEL_INDEX, '0, '0, '0, '0, '0, 5'd0));         // already empty
    issue_request(mk_req(OP_ADD, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 8'd255, '0));
    issue_request(mk_req(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0, '0));
    issue_request(mk_req(OP_ADD, '0, 32'h0A00_0000, 32'hFFFF_0000, 32'h0101_0101, 8'd1,
                         '0));                                              // same net, new mask
    issue_request(mk_req(OP_DEL_IFACE, '0, '0, '0, '0, 8'd7, '0));
    issue_request(mk_req(OP_LOOKUP, 32'h0A00_0001, '0, '0, '0, '0, '0));
    issue_request(mk_req(OP_DEL_INDEX, '0, '0, '0, '0, '0, 5'd31));
    issue_request(mk_req(OP_FIRST_UNUSED, '1, '1, '1, '1, '1, '1));
    issue_request(mk_req(OP_LAST_UNUSED, '1, '1, '1, '1, '1, '1));
    issue_request(mk_req(OP_FIRST_UNUSED + 3'd1, '0, '0, '0, '0, '0, '0));
    issue_request(mk_req(OP_CLEAR, '1, '1, '1, '1, '1, '1));
    issue_request(mk_req(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, '0, '0));
    issue_request(mk_req(OP_ADD, '0, 32'h0A00_00FF, 32'hFFFF_FF00, 32'h0, 8'd2, '0));
    issue_request(mk_req(OP_LOOKUP, 32'h0A00_0011, '0, '0, '0, '0, '0));   // masked compare
  endtask

  // fill every slot, then keep adding so the replace pointer wraps
  task automatic test_full_table();
    req_t r;
    int   k;
    issue_request(mk_req(OP_CLEAR, '0, '0, '0, '0, '0, '0));
    for (int n = 0; n < ROUTE_ENTRIES + 40; n++) begin
      r = random_background();
      r.op = OP_ADD;
      r.net_addr = ($urandom & 32'hFFFF_FF00) | 32'(n);
      r.net_mask = random_mask();
      r.gateway = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
      issue_request(r);
      if (n % 4 == 3) begin
        // slots fill in index order, so only slots up to n hold a route yet
        k = $urandom_range((n < ROUTE_ENTRIES) ? n : ROUTE_ENTRIES - 1);
        r = random_background();
        r.op = OP_LOOKUP;
        r.dest_addr = (tbl_net[k] & tbl_mask[k]) | ($urandom & ~tbl_mask[k]);
        issue_request(r);
      end
    end
    // on a full table an update keeps the pointer, a freed slot is reused first
    k = $urandom_range(ROUTE_ENTRIES - 1);
    issue_request(mk_req(OP_ADD, '0, tbl_net[k], tbl_mask[k], $urandom, 8'($urandom), '0));
    issue_request(mk_req(OP_DEL_INDEX, '0, '0, '0, '0, '0, 5'(k)));
    issue_request(mk_req(OP_ADD, '0, $urandom, 32'hFFFF_FFFF, $urandom, 8'($urandom), '0));
    issue_request(mk_req(OP_ADD, '0, $urandom, 32'hFFFF_FFFF, $urandom, 8'($urandom), '0));
  endtask

  task automatic test_route_churn(input int count);
    req_t r;
    int   sel;
    int   k;
    int   profile;
    profile = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) profile = $urandom_range(2);
      sel = $urandom_range(99);
      r = random_background();
      // profile 0 fills the table, 1 mixes, 2 leans on removal
      case (profile)
        0:       r.op = (sel < 55) ? OP_ADD : (sel < 90) ? OP_LOOKUP : (sel < 95) ? OP_DEL_INDEX :
                        (sel < 98) ? OP_DEL_IFACE : (sel < 99) ? OP_CLEAR : OP_LAST_UNUSED;
        1:       r.op = (sel < 35) ? OP_ADD : (sel < 80) ? OP_LOOKUP : (sel < 90) ? OP_DEL_INDEX :
                        (sel < 96) ? OP_DEL_IFACE : (sel < 98) ? OP_CLEAR : OP_FIRST_UNUSED;
        default: r.op = (sel < 25) ? OP_ADD : (sel < 65) ? OP_LOOKUP : (sel < 85) ? OP_DEL_INDEX :
                        (sel < 95) ? OP_DEL_IFACE : (sel < 97) ? OP_CLEAR :
                        3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      endcase
      case (r.op)
        OP_ADD: begin
          if ($urandom_range(3) != 0) begin
            k = $urandom_range(POOL_SIZE - 1);
            r.net_addr = pool_net[k];
            r.net_mask = pool_mask[k];
          end else begin
            r.net_mask = random_mask();
          end
          if ($urandom_range(2) == 0) r.gateway = '0;
          if ($urandom_range(9) != 0) r.iface_id = iface_pool[$urandom_range(5)];
        end
        OP_LOOKUP: begin
          if ($urandom_range(99) < 65) begin
            k = $urandom_range(ROUTE_ENTRIES - 1);
            if (tbl_valid[k])
              r.dest_addr = (tbl_net[k] & tbl_mask[k]) | ($urandom & ~tbl_mask[k]);
            else begin
              k = $urandom_range(POOL_SIZE - 1);
              r.dest_addr = (pool_net[k] & pool_mask[k]) | ($urandom & ~pool_mask[k]);
            end
          end
        end
        OP_DEL_IFACE: begin
          if ($urandom_range(9) != 0) r.iface_id = iface_pool[$urandom_range(5)];
        end
        default: ;
      endcase
      issue_request(r);
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.op          <= '0;
    req_if.dest_addr   <= '0;
    req_if.net_addr    <= '0;
    req_if.net_mask    <= '0;
    req_if.gateway     <= '0;
    req_if.iface_id    <= '0;
    req_if.entry_index <= '0;
    error_count    = 0;
    mismatch_count = 0;
    send_idle_pct  = 19;
    recv_idle_pct  = 54;
    for (int k = 0; k < ROUTE_ENTRIES; k++) tbl_valid[k] = 1'b0;
    repl_ptr = '0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_mask[k] = random_mask();
      // some pool networks keep host bits set, so they differ from their masked form
      pool_net[k] = ($urandom_range(3) == 0) ? $urandom : ($urandom & pool_mask[k]);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    test_route_churn(540);
    send_idle_pct = 54;
    recv_idle_pct = 19;
    test_route_churn(540);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_route_churn(470);

    quiet_request();
    while (route_answers_q.size() != 0) @(posedge clk_i);
    repeat (ROUTE_ENTRIES + 8) @(posedge clk_i);
    if (error_count == 0 && route_answers_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
